// ===== sv/sfms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_pkg
// shared types and constants of the first-match substring search
// ----------------------------------------------------------------------------
package sfms_pkg;

  localparam int CHAR_W            = 16;
  localparam int START_W           = 16;
  localparam int MATCH_POS_W       = 16;
  localparam int MAX_PATTERN_DEF   = 64;
  localparam int POSITION_BITS_DEF = 16;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_PAT_LONG   = 2'd2,
    STATUS_TEXT_LONG  = 2'd3
  } status_t;

  // input word mode
  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              write;  // pattern char written somewhere this cycle
    logic              shift;  // text char advances the match chain
    logic              clear;  // drop partial matches
    logic [CHAR_W-1:0] ch;     // char of the word being taken
  } cell_ctrl_t;

endpackage

// ===== sv/sfms_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_char_if
// input channel: one pattern or text char per word
// ----------------------------------------------------------------------------
interface sfms_char_if import sfms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_value;
  logic              last_char;

  modport source (output valid, output mode, output char_value, output last_char,
                  input ready);
  modport sink   (input valid, input mode, input char_value, input last_char,
                  output ready);
endinterface

// ===== sv/sfms_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_result_if
// output channel: one search result per word
// ----------------------------------------------------------------------------
interface sfms_result_if import sfms_pkg::*; ();
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [MATCH_POS_W-1:0] match_position;

  modport source (output valid, output status, output match_position, input ready);
  modport sink   (input valid, input status, input match_position, output ready);
endinterface

// ===== sv/sfms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_cell
// one pattern position: holds its pattern char, its end-of-pattern flag and
// the partial match bit that it hands to the next cell
// ----------------------------------------------------------------------------
module sfms_cell import sfms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,        // this cell is the write target
  input  logic       match_prev, // partial match of the previous cell
  output logic       match,      // pattern[0..k] ends at the last text char
  output logic       hit         // full pattern ends at the incoming char
);

  logic [CHAR_W-1:0] pchar;
  logic              is_last;
  logic              match_next;

  assign match_next = match_prev && (pchar == ctrl.ch);
  assign hit        = ctrl.shift && match_next && is_last;

  always_ff @(posedge clk) begin
    if (ctrl.write && sel) begin
      pchar <= ctrl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_last <= 1'b0;
      match   <= 1'b0;
    end else begin
      if (ctrl.write) begin
        is_last <= sel;
      end
      if (ctrl.clear) begin
        match <= 1'b0;
      end else if (ctrl.shift) begin
        match <= match_next;
      end
    end
  end

endmodule

// ===== sv/substring_first_match_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match_search
// the result of a final text char is on the output in the cycle after the
// char is taken; one char per cycle while no held result stalls the input,
// set by the cell chain comparing every pattern position in the same cycle
// reset: pattern, text state and start position cleared; the pattern chars
// themselves are not cleared and are only used once written
// ----------------------------------------------------------------------------
module substring_first_match_search import sfms_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [START_W-1:0] cfg_wr_data,
  sfms_char_if.sink          chars,
  sfms_result_if.source      results
);

  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int TP_W  = POSITION_BITS + 1;
  // compare width for candidate start against the start register
  localparam int CMP_W = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
  localparam logic [TP_W-1:0]  POS_LIMIT = TP_W'(1) << POSITION_BITS;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_PATTERN);

  // config register
  logic [START_W-1:0] start_position;

  // pattern state
  logic [LEN_W-1:0] pattern_length;
  logic             pattern_complete;
  logic             pattern_overflow;

  // text state
  logic [TP_W-1:0]          text_position;
  logic                     match_found;
  logic [POSITION_BITS-1:0] found_position;

  // output register
  logic                   res_valid;
  status_t                res_status;
  logic [MATCH_POS_W-1:0] res_pos;

  // handshake: a new word may enter while the result register drains
  logic accept;
  logic is_text;
  assign chars.ready = !res_valid || results.ready;
  assign accept      = chars.valid && chars.ready;
  assign is_text     = (chars.mode == MODE_TEXT);

  assign results.valid          = res_valid;
  assign results.status         = res_status;
  assign results.match_position = res_pos;

  // pattern load: a char after a completed pattern starts a new one
  logic [LEN_W-1:0] eff_len;
  logic             room;
  logic             pat_write;
  assign eff_len   = pattern_complete ? '0 : pattern_length;
  assign room      = (eff_len < LEN_MAX);
  assign pat_write = accept && !is_text && room;

  // text position below the limit keeps matching
  logic under_limit;
  logic shift;
  assign under_limit = !text_position[POSITION_BITS];
  assign shift       = accept && is_text && under_limit;

  logic text_done;
  assign text_done = accept && is_text && chars.last_char;

  cell_ctrl_t ctrl;
  always_comb begin
    ctrl.write = pat_write;
    ctrl.shift = shift;
    // any pattern char or a finished text drops the partial matches
    ctrl.clear = (accept && !is_text) || text_done;
    ctrl.ch    = chars.char_value;
  end

  // chain of cells, cell k matches pattern[k] and passes its bit to k+1
  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0] cell_hit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = cell_match[k-1];
    end
    sfms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sel        (eff_len[IDX_W-1:0] == IDX_W'(k)),
      .match_prev (prev),
      .match      (cell_match[k]),
      .hit        (cell_hit[k])
    );
  end

  // only the cell at the pattern's end can raise a hit
  logic hit;
  assign hit = |cell_hit;

  // start of the match ending at this char: position + 1 - length
  logic [TP_W-1:0]          start_full;
  logic [POSITION_BITS-1:0] cand_start;
  logic                     start_ok;
  logic                     take_match;
  assign start_full = text_position + TP_W'(1) - TP_W'(pattern_length);
  assign cand_start = start_full[POSITION_BITS-1:0];
  assign start_ok   = (CMP_W'(cand_start) >= CMP_W'(start_position));
  assign take_match = hit && !match_found && !pattern_overflow && start_ok;

  // text state after this char
  logic [TP_W-1:0]          tpos_next;
  logic                     found_next;
  logic [POSITION_BITS-1:0] fpos_next;
  always_comb begin
    tpos_next  = text_position;
    found_next = match_found;
    fpos_next  = found_position;
    if (under_limit) begin
      tpos_next = text_position + TP_W'(1);
    end else begin
      tpos_next = POS_LIMIT + TP_W'(1);
    end
    if (take_match) begin
      found_next = 1'b1;
      fpos_next  = cand_start;
    end
  end

  // result of a final text char, overflow first
  status_t                status_next;
  logic [MATCH_POS_W-1:0] pos_next;
  always_comb begin
    status_next = STATUS_NOT_FOUND;
    pos_next    = '0;
    if (pattern_overflow) begin
      status_next = STATUS_PAT_LONG;
    end else if (tpos_next > POS_LIMIT) begin
      status_next = STATUS_TEXT_LONG;
    end else if (found_next) begin
      status_next = STATUS_FOUND;
      pos_next    = MATCH_POS_W'(fpos_next);
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
    end else if (cfg_wr_en) begin
      start_position <= cfg_wr_data;
    end
  end

  // pattern bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      pattern_complete <= 1'b0;
      pattern_overflow <= 1'b0;
    end else if (accept && !is_text) begin
      pattern_complete <= chars.last_char;
      if (room) begin
        pattern_length   <= eff_len + LEN_W'(1);
        pattern_overflow <= pattern_complete ? 1'b0 : pattern_overflow;
      end else begin
        pattern_length   <= eff_len;
        pattern_overflow <= 1'b1;
      end
    end
  end

  // text bookkeeping, cleared by a pattern char or a finished text
  always_ff @(posedge clk) begin
    if (rst) begin
      text_position  <= '0;
      match_found    <= 1'b0;
      found_position <= '0;
    end else if (accept) begin
      if (!is_text || chars.last_char) begin
        text_position  <= '0;
        match_found    <= 1'b0;
        found_position <= '0;
      end else begin
        text_position  <= tpos_next;
        match_found    <= found_next;
        found_position <= fpos_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (text_done) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_done) begin
      res_status <= status_next;
      res_pos    <= pos_next;
    end
  end

endmodule
